>>> src/sat_pkg.sv
package sat_pkg;

  // Field widths of the channels
  localparam int unsigned ELEM_W     = 16;
  localparam int unsigned COORD_W    = 6;
  localparam int unsigned SUM_W      = 29;
  localparam int unsigned STATUS_W   = 2;
  localparam int unsigned CFG_IDX_W  = 2;
  localparam int unsigned CFG_DATA_W = 7;

  // Default table size
  localparam int unsigned DEF_MAX_ROWS = 64;
  localparam int unsigned DEF_MAX_COLS = 64;

  // Size registers come out of reset at this value, then clamped
  localparam logic [CFG_DATA_W-1:0] CFG_RESET_SIZE = 7'd64;

  // Configuration register indexes
  localparam logic [CFG_IDX_W-1:0] CFG_ROWS = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_COLS = 2'd1;

  // Action codes of an input word
  localparam logic ACT_LOAD  = 1'b0;
  localparam logic ACT_QUERY = 1'b1;

  typedef enum logic [STATUS_W-1:0] {
    ST_OK        = 2'd0,
    ST_BAD_RECT  = 2'd1,
    ST_NOT_READY = 2'd2
  } sat_status_t;

  typedef enum logic [2:0] {
    S_IDLE,
    S_LOAD,
    S_Q1,
    S_Q2,
    S_Q3,
    S_Q4,
    S_OUT
  } sat_state_t;

endpackage

>>> src/sat_if.sv
interface sat_in_if;
  import sat_pkg::*;

  logic                      valid;
  logic                      ready;
  logic                      action;
  logic signed [ELEM_W-1:0]  element_value;
  logic [COORD_W-1:0]        top_row;
  logic [COORD_W-1:0]        left_col;
  logic [COORD_W-1:0]        bottom_row;
  logic [COORD_W-1:0]        right_col;

  modport source (
    output valid, action, element_value, top_row, left_col, bottom_row, right_col,
    input  ready
  );
  modport sink (
    input  valid, action, element_value, top_row, left_col, bottom_row, right_col,
    output ready
  );
endinterface

interface sat_out_if;
  import sat_pkg::*;

  logic                     valid;
  logic                     ready;
  logic signed [SUM_W-1:0]  region_sum;
  logic [STATUS_W-1:0]      status;

  modport source (
    output valid, region_sum, status,
    input  ready
  );
  modport sink (
    input  valid, region_sum, status,
    output ready
  );
endinterface

>>> src/sat_ram.sv
module sat_ram #(
  parameter int unsigned AW = 12,
  parameter int unsigned DW = 29
) (
  input  logic          clk,
  input  logic          we,
  input  logic          re,
  input  logic [AW-1:0] addr,
  input  logic [DW-1:0] wdata,
  output logic [DW-1:0] rdata
);
  localparam int unsigned DEPTH = 1 << AW;

  logic [DW-1:0] mem [DEPTH];
  logic [DW-1:0] rdata_r;

  // Single port, registered read
  always_ff @(posedge clk) begin
    if (we) begin
      mem[addr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem[addr];
    end
  end

  assign rdata = rdata_r;

endmodule

>>> src/summed_area_table_region_sum.sv
// Summed-area table with rectangle region-sum queries.
//
// Input channel in_word: action 0 loads the next matrix element in raster
// order (rows_in_use x cols_in_use elements); action 1 queries the inclusive
// rectangle top_row..bottom_row x left_col..right_col. Loads give no result
// word; each query gives one result word on out_word (region_sum, status).
// A load after the table is complete starts a new table.
// Configuration port cfg_*: index 0 rows_in_use, 1 cols_in_use; a write
// clamps the value to the table size and restarts loading.
//
// A load reads the entry above, then writes the new entry back. A query
// makes four reads through the single port of the table memory, one per
// cycle; its result word is valid in the cycle after the last read data arrives
// if the output register is free. An error query goes straight to the output state.
// in_word.ready is high whenever the controller is idle, also while a result
// word waits in the output register; a query that finishes while the
// receiver stalls holds in place until the output register frees up.
// Reset clears the load position, the running sum and the ready flag and sets
// both sizes to 64 (clamped); the table memory itself is not cleared.
module summed_area_table_region_sum #(
  parameter int unsigned MAX_ROWS = sat_pkg::DEF_MAX_ROWS,
  parameter int unsigned MAX_COLS = sat_pkg::DEF_MAX_COLS
) (
  input  logic                             clk,
  input  logic                             rst_n,
  input  logic                             cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]    cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0]   cfg_data,
  sat_in_if.sink                           in_word,
  sat_out_if.source                        out_word
);
  import sat_pkg::*;

  localparam int unsigned RAW    = (MAX_ROWS > 1) ? $clog2(MAX_ROWS) : 1;
  localparam int unsigned CAW    = (MAX_COLS > 1) ? $clog2(MAX_COLS) : 1;
  localparam int unsigned AW     = RAW + CAW;
  localparam int unsigned RSUM_W = ELEM_W + CAW;
  localparam int unsigned CMAX_W = (RAW > CAW) ? RAW : CAW;
  localparam int unsigned CNT_W  = ((CMAX_W > CFG_DATA_W) ? CMAX_W : CFG_DATA_W) + 1;

  function automatic logic [CFG_DATA_W-1:0] clamp_size(
    input logic [CFG_DATA_W-1:0] v,
    input int unsigned           maxv
  );
    logic [CFG_DATA_W-1:0] res;
    res = v;
    if (v == '0) begin
      res = CFG_DATA_W'(1);
    end else if (v > maxv) begin
      res = CFG_DATA_W'(maxv);
    end
    return res;
  endfunction

  // Control state
  sat_state_t               state_r, state_nxt;
  logic [RAW-1:0]           load_row_r, load_row_nxt;
  logic [CAW-1:0]           load_col_r, load_col_nxt;
  logic signed [RSUM_W-1:0] rsum_r, rsum_nxt;
  logic                     table_ready_r, table_ready_nxt;
  logic [CFG_DATA_W-1:0]    rows_r, rows_nxt;
  logic [CFG_DATA_W-1:0]    cols_r, cols_nxt;
  logic                     out_valid_r, out_valid_nxt;

  // Payload registers
  logic signed [ELEM_W-1:0] elem_r;
  logic [RAW-1:0]           qrow_b_r, qrow_a_r;
  logic [CAW-1:0]           qcol_r_r, qcol_l_r;
  logic                     qtop_nz_r, qleft_nz_r;
  logic signed [SUM_W-1:0]  acc_r, acc_nxt;
  sat_status_t              status_r, status_nxt;
  logic signed [SUM_W-1:0]  out_sum_r;
  sat_status_t              out_status_r;

  // Handshake
  logic in_fire, ld_fire, q_fire, out_free, out_load;
  logic rect_bad;

  // Table memory port
  logic                     ram_we, ram_re;
  logic [AW-1:0]            ram_addr;
  logic [SUM_W-1:0]         ram_wdata, ram_rdata;
  logic signed [SUM_W-1:0]  rd_val;

  // Load datapath
  logic signed [RSUM_W-1:0] rsum_add;
  logic signed [SUM_W-1:0]  above_val, entry_val, final_sum;
  logic                     col_last, row_last;

  assign in_word.ready = (state_r == S_IDLE);
  assign in_fire  = in_word.valid & in_word.ready;
  assign ld_fire  = in_fire & (in_word.action == ACT_LOAD);
  assign q_fire   = in_fire & (in_word.action == ACT_QUERY);
  assign out_free = !out_valid_r || out_word.ready;

  assign rect_bad = (in_word.top_row > in_word.bottom_row)
                 || (in_word.left_col > in_word.right_col)
                 || (CFG_DATA_W'(in_word.bottom_row) >= rows_r)
                 || (CFG_DATA_W'(in_word.right_col) >= cols_r);

  assign rd_val = ram_rdata;

  // Load arithmetic: running sum of the row plus the entry above
  assign rsum_add  = rsum_r + RSUM_W'(elem_r);
  assign above_val = (load_row_r != '0) ? rd_val : '0;
  assign entry_val = above_val + SUM_W'(rsum_add);
  assign ram_wdata = entry_val;
  assign col_last  = (CNT_W'(load_col_r) + CNT_W'(1)) >= CNT_W'(cols_r);
  assign row_last  = (CNT_W'(load_row_r) + CNT_W'(1)) >= CNT_W'(rows_r);

  // Last query term goes straight to the output register
  assign final_sum = acc_r + ((qtop_nz_r && qleft_nz_r) ? rd_val : '0);

  // Next state
  always_comb begin
    state_nxt = state_r;
    unique case (state_r)
      S_IDLE: begin
        if (ld_fire) begin
          state_nxt = S_LOAD;
        end else if (q_fire) begin
          state_nxt = (table_ready_r && !rect_bad) ? S_Q1 : S_OUT;
        end
      end
      S_LOAD: state_nxt = S_IDLE;
      S_Q1:   state_nxt = S_Q2;
      S_Q2:   state_nxt = S_Q3;
      S_Q3:   state_nxt = S_Q4;
      S_Q4:   state_nxt = out_free ? S_IDLE : S_OUT;
      S_OUT:  state_nxt = out_free ? S_IDLE : S_OUT;
      default: state_nxt = S_IDLE;
    endcase
  end

  // Memory port and output register control
  always_comb begin
    ram_we   = 1'b0;
    ram_re   = 1'b0;
    ram_addr = '0;
    out_load = 1'b0;
    unique case (state_r)
      S_IDLE: begin
        ram_re = in_fire;
        if (in_word.action == ACT_QUERY) begin
          ram_addr = {RAW'(in_word.bottom_row), CAW'(in_word.right_col)};
        end else begin
          ram_addr = {load_row_r - RAW'(1), load_col_r};
        end
      end
      S_LOAD: begin
        ram_we   = 1'b1;
        ram_addr = {load_row_r, load_col_r};
      end
      S_Q1: begin
        ram_re   = 1'b1;
        ram_addr = {qrow_b_r, qcol_l_r};
      end
      S_Q2: begin
        ram_re   = 1'b1;
        ram_addr = {qrow_a_r, qcol_r_r};
      end
      S_Q3: begin
        ram_re   = 1'b1;
        ram_addr = {qrow_a_r, qcol_l_r};
      end
      S_Q4:  out_load = out_free;
      S_OUT: out_load = out_free;
      default: ;
    endcase
  end

  // Load position, running sum, sizes and accumulator
  always_comb begin
    load_row_nxt    = load_row_r;
    load_col_nxt    = load_col_r;
    rsum_nxt        = rsum_r;
    table_ready_nxt = table_ready_r;
    rows_nxt        = rows_r;
    cols_nxt        = cols_r;
    acc_nxt         = acc_r;
    status_nxt      = status_r;

    unique case (state_r)
      S_IDLE: begin
        if (ld_fire) begin
          table_ready_nxt = 1'b0;
        end else if (q_fire) begin
          acc_nxt = '0;
          if (!table_ready_r) begin
            status_nxt = ST_NOT_READY;
          end else if (rect_bad) begin
            status_nxt = ST_BAD_RECT;
          end else begin
            status_nxt = ST_OK;
          end
        end
      end
      S_LOAD: begin
        if (col_last) begin
          load_col_nxt = '0;
          rsum_nxt     = '0;
          if (row_last) begin
            load_row_nxt    = '0;
            table_ready_nxt = 1'b1;
          end else begin
            load_row_nxt = load_row_r + RAW'(1);
          end
        end else begin
          load_col_nxt = load_col_r + CAW'(1);
          rsum_nxt     = rsum_add;
        end
      end
      S_Q1: acc_nxt = rd_val;
      S_Q2: acc_nxt = acc_r - (qleft_nz_r ? rd_val : '0);
      S_Q3: acc_nxt = acc_r - (qtop_nz_r ? rd_val : '0);
      S_Q4: acc_nxt = final_sum;
      S_OUT: ;
      default: ;
    endcase

    // Size writes restart loading
    if (cfg_we && (cfg_index == CFG_ROWS || cfg_index == CFG_COLS)) begin
      if (cfg_index == CFG_ROWS) begin
        rows_nxt = clamp_size(cfg_data, MAX_ROWS);
      end else begin
        cols_nxt = clamp_size(cfg_data, MAX_COLS);
      end
      load_row_nxt    = '0;
      load_col_nxt    = '0;
      rsum_nxt        = '0;
      table_ready_nxt = 1'b0;
    end
  end

  assign out_valid_nxt = out_load ? 1'b1 : (out_word.ready ? 1'b0 : out_valid_r);

  // Control registers
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r       <= S_IDLE;
      load_row_r    <= '0;
      load_col_r    <= '0;
      rsum_r        <= '0;
      table_ready_r <= 1'b0;
      rows_r        <= clamp_size(CFG_RESET_SIZE, MAX_ROWS);
      cols_r        <= clamp_size(CFG_RESET_SIZE, MAX_COLS);
      out_valid_r   <= 1'b0;
    end else begin
      state_r       <= state_nxt;
      load_row_r    <= load_row_nxt;
      load_col_r    <= load_col_nxt;
      rsum_r        <= rsum_nxt;
      table_ready_r <= table_ready_nxt;
      rows_r        <= rows_nxt;
      cols_r        <= cols_nxt;
      out_valid_r   <= out_valid_nxt;
    end
  end

  // Payload registers
  always_ff @(posedge clk) begin
    acc_r    <= acc_nxt;
    status_r <= status_nxt;
    if (ld_fire) begin
      elem_r <= in_word.element_value;
    end
    if (q_fire) begin
      qrow_b_r   <= RAW'(in_word.bottom_row);
      qrow_a_r   <= RAW'(in_word.top_row - COORD_W'(1));
      qcol_r_r   <= CAW'(in_word.right_col);
      qcol_l_r   <= CAW'(in_word.left_col - COORD_W'(1));
      qtop_nz_r  <= (in_word.top_row != '0);
      qleft_nz_r <= (in_word.left_col != '0);
    end
    if (out_load) begin
      out_sum_r    <= (state_r == S_Q4) ? final_sum : acc_r;
      out_status_r <= status_r;
    end
  end

  assign out_word.valid      = out_valid_r;
  assign out_word.region_sum = out_sum_r;
  assign out_word.status     = out_status_r;

  sat_ram #(
    .AW (AW),
    .DW (SUM_W)
  ) u_table (
    .clk   (clk),
    .we    (ram_we),
    .re    (ram_re),
    .addr  (ram_addr),
    .wdata (ram_wdata),
    .rdata (ram_rdata)
  );

  // A complete table always leaves the load position at the origin
  a_ready_origin: assert property (@(posedge clk) disable iff (!rst_n)
    table_ready_r |-> (load_row_r == '0 && load_col_r == '0 && rsum_r == '0))
    else $error("table ready with load position not at origin");

  // Query before the table is complete reports not-ready
  a_not_ready: assert property (@(posedge clk) disable iff (!rst_n)
    (q_fire && !table_ready_r) |=> (state_r == S_OUT && status_r == ST_NOT_READY))
    else $error("early query not flagged as not ready");

  // Error words carry a zero sum
  a_err_zero: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid_r && out_status_r != ST_OK) |-> (out_sum_r == '0))
    else $error("error result with non-zero sum");

  // Table is never written while a query walks it
  a_no_write_query: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_Q1 || state_r == S_Q2 || state_r == S_Q3 || state_r == S_Q4
     || state_r == S_OUT) |-> !ram_we)
    else $error("table written during a query");

  // A load write-back lasts one cycle
  a_load_one_cycle: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_LOAD) |=> (state_r == S_IDLE))
    else $error("load write-back did not return to idle");

endmodule

>>> tb/sat_region_checker.sv
`timescale 1ns / 1ps

// Watches the load/query and result channels plus the register port,
// keeps a shadow of the summed-area table and checks every result word.
module sat_region_checker (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [sat_pkg::CFG_IDX_W-1:0]  cfg_index,
  input  logic [sat_pkg::CFG_DATA_W-1:0] cfg_data,
  sat_in_if                              in_mon,
  sat_out_if                             out_mon,
  output int unsigned                    mismatch_total,
  output int unsigned                    words_waiting
);
  import sat_pkg::*;

  typedef struct packed {
    logic signed [SUM_W-1:0] sum;
    sat_status_t             status;
  } region_result_t;

  // Shadow table and load position
  logic signed [SUM_W-1:0] sat_mem [DEF_MAX_ROWS][DEF_MAX_COLS];
  logic signed [21:0]      run_sum;
  int unsigned             ld_row;
  int unsigned             ld_col;
  bit                      tbl_ready;
  int unsigned             rows_used;
  int unsigned             cols_used;

  region_result_t          pending_sums[$];

  initial begin
    mismatch_total = 0;
    words_waiting  = 0;
  end

  function automatic void restart_table();
    ld_row    = 0;
    ld_col    = 0;
    run_sum   = '0;
    tbl_ready = 1'b0;
  endfunction

  function automatic int unsigned clamp_size(logic [CFG_DATA_W-1:0] val, int unsigned lim);
    if (val == 0) return 1;
    if (val > lim) return lim;
    return 32'(val);
  endfunction

  // Register write: clamp, then loading starts over
  function automatic void write_register(logic [CFG_IDX_W-1:0] idx,
                                         logic [CFG_DATA_W-1:0] val);
    case (idx)
      CFG_ROWS: begin
        rows_used = clamp_size(val, DEF_MAX_ROWS);
        restart_table();
      end
      CFG_COLS: begin
        cols_used = clamp_size(val, DEF_MAX_COLS);
        restart_table();
      end
      default: ;
    endcase
  endfunction

  // Apply one accepted word; returns 1 when it yields a result word
  function automatic bit step_word(input logic act, input logic signed [ELEM_W-1:0] elem,
                                   input logic [COORD_W-1:0] t, l, b, r,
                                   output region_result_t res);
    logic signed [SUM_W-1:0] above;
    logic signed [SUM_W-1:0] row_ext;
    logic signed [SUM_W-1:0] acc;
    res = '0;
    if (act == ACT_LOAD) begin
      // a load after a complete table begins a new one
      if (tbl_ready) restart_table();
      run_sum = run_sum + 22'(elem);
      above   = (ld_row > 0) ? sat_mem[ld_row-1][ld_col] : '0;
      row_ext = SUM_W'(run_sum);
      sat_mem[ld_row][ld_col] = above + row_ext;
      ld_col++;
      if (ld_col >= cols_used) begin
        ld_col  = 0;
        run_sum = '0;
        ld_row++;
        if (ld_row >= rows_used) begin
          ld_row    = 0;
          tbl_ready = 1'b1;
        end
      end
      return 1'b0;
    end
    // query: readiness first, then the rectangle
    if (!tbl_ready) begin
      res.status = ST_NOT_READY;
    end else if (t > b || l > r || b >= rows_used || r >= cols_used) begin
      res.status = ST_BAD_RECT;
    end else begin
      acc = sat_mem[b][r];
      if (l > 0) acc = acc - sat_mem[b][l-1];
      if (t > 0) acc = acc - sat_mem[t-1][r];
      if (t > 0 && l > 0) acc = acc + sat_mem[t-1][l-1];
      res.sum    = acc;
      res.status = ST_OK;
    end
    return 1'b1;
  endfunction

  always @(posedge clk) begin
    region_result_t want;
    region_result_t got;
    if (!rst_n) begin
      rows_used = DEF_MAX_ROWS;
      cols_used = DEF_MAX_COLS;
      restart_table();
      pending_sums.delete();
    end else begin
      // result side first: a word accepted on this edge cannot be answered yet
      if (out_mon.valid && out_mon.ready) begin
        if (pending_sums.size() == 0) begin
          if (mismatch_total < 10)
            $display("%0t: result word with nothing expected: sum %0d status %0d",
                     $realtime, out_mon.region_sum, out_mon.status);
          mismatch_total++;
        end else begin
          want = pending_sums.pop_front();
          if (out_mon.region_sum !== want.sum || out_mon.status !== want.status) begin
            if (mismatch_total < 10)
              $display("%0t: mismatch: sum exp %0d got %0d, status exp %0d got %0d",
                       $realtime, want.sum, out_mon.region_sum, want.status,
                       out_mon.status);
            mismatch_total++;
          end
        end
      end
      if (cfg_we) write_register(cfg_index, cfg_data);
      if (in_mon.valid && in_mon.ready) begin
        if (step_word(in_mon.action, in_mon.element_value, in_mon.top_row,
                      in_mon.left_col, in_mon.bottom_row, in_mon.right_col, got))
          pending_sums = {pending_sums, got};
      end
    end
    words_waiting <= pending_sums.size();
  end

endmodule

>>> tb/tb_top.sv
`timescale 1ns / 1ps

module tb_top;
  import sat_pkg::*;

  localparam int unsigned WORD_TARGET = 1550;
  localparam int unsigned HOLD_CYCLES = 200;
  // indexes past the last register, to be ignored by the block
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_A = 2'd2;
  localparam logic [CFG_IDX_W-1:0] CFG_SPARE_B = 2'd3;

  logic                  clk;
  logic                  rst_n;
  logic                  cfg_we;
  logic [CFG_IDX_W-1:0]  cfg_index;
  logic [CFG_DATA_W-1:0] cfg_data;

  int unsigned mismatch_total;
  int unsigned words_waiting;
  int unsigned words_sent    = 0;
  int unsigned send_idle_pct = 35;
  int unsigned recv_idle_pct = 68;
  int unsigned rx_hold_left  = 0;
  bit          rx_hold_go    = 1'b0;
  bit          hold_done     = 1'b0;
  int unsigned rows_now;
  int unsigned cols_now;

  sat_in_if  in_bus ();
  sat_out_if out_bus ();

  summed_area_table_region_sum u_top (
    .clk       (clk),
    .rst_n     (rst_n),
    .cfg_we    (cfg_we),
    .cfg_index (cfg_index),
    .cfg_data  (cfg_data),
    .in_word   (in_bus),
    .out_word  (out_bus)
  );

  sat_region_checker u_check (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_index      (cfg_index),
    .cfg_data       (cfg_data),
    .in_mon         (in_bus),
    .out_mon        (out_bus),
    .mismatch_total (mismatch_total),
    .words_waiting  (words_waiting)
  );

  initial clk = 1'b0;
  always #1 clk = ~clk;

  // Run limit
  initial begin
    #2_000_000;
    $display("*** FAILED ***");
    $finish;
  end

  // Result receiver: random stalls, plus one long hold-off on request
  always @(negedge clk) begin
    if (rx_hold_go) begin
      rx_hold_go   = 1'b0;
      rx_hold_left = HOLD_CYCLES;
    end
    if (rx_hold_left != 0) begin
      rx_hold_left--;
      out_bus.ready <= 1'b0;
    end else begin
      out_bus.ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  // One word on the input channel, with random idle cycles ahead of it
  task automatic drive_word(input logic act, input logic signed [ELEM_W-1:0] elem,
                            input logic [COORD_W-1:0] t, l, b, r);
    while ($urandom_range(99) < send_idle_pct) begin
      in_bus.valid <= 1'b0;
      @(negedge clk);
    end
    in_bus.valid         <= 1'b1;
    in_bus.action        <= act;
    in_bus.element_value <= elem;
    in_bus.top_row       <= t;
    in_bus.left_col      <= l;
    in_bus.bottom_row    <= b;
    in_bus.right_col     <= r;
    do @(posedge clk); while (!in_bus.ready);
    @(negedge clk);
    words_sent++;
    // idle profile: sender light/receiver heavy, then swapped, then none
    if (words_sent >= 2 * WORD_TARGET / 3) begin
      send_idle_pct = 0;
      recv_idle_pct = 0;
    end else if (words_sent >= WORD_TARGET / 3) begin
      send_idle_pct = 68;
      recv_idle_pct = 35;
    end
  endtask

  task automatic send_load(input logic signed [ELEM_W-1:0] elem);
    drive_word(ACT_LOAD, elem, COORD_W'($urandom), COORD_W'($urandom),
               COORD_W'($urandom), COORD_W'($urandom));
  endtask

  task automatic send_query(input logic [COORD_W-1:0] t, l, b, r);
    drive_word(ACT_QUERY, ELEM_W'($urandom), t, l, b, r);
  endtask

  function automatic logic signed [ELEM_W-1:0] pick_element();
    case ($urandom_range(7))
      0:       return 16'sh7FFF;
      1:       return 16'sh8000;
      default: return ELEM_W'($urandom);
    endcase
  endfunction

  // Register write, then the enable drops for a cycle
  task automatic write_reg(input logic [CFG_IDX_W-1:0] idx,
                           input logic [CFG_DATA_W-1:0] val);
    int unsigned sz;
    sz = (val == 0) ? 1 : ((val > DEF_MAX_ROWS) ? DEF_MAX_ROWS : val);
    cfg_we    <= 1'b1;
    cfg_index <= idx;
    cfg_data  <= val;
    @(negedge clk);
    cfg_we <= 1'b0;
    @(negedge clk);
    if (idx == CFG_ROWS) rows_now = sz;
    else if (idx == CFG_COLS) cols_now = sz;
  endtask

  // Wait until every result word is in, then let a trailing load finish
  task automatic settle();
    in_bus.valid <= 1'b0;
    while (words_waiting != 0) @(negedge clk);
    repeat (8) @(negedge clk);
  endtask

  // Full raster load with the odd early query mixed in
  task automatic fill_table();
    for (int unsigned i = 0; i < rows_now * cols_now; i++) begin
      if ($urandom_range(9) == 0)
        send_query(COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom));
      send_load(pick_element());
    end
  endtask

  // Mostly rectangles inside the table, the rest anywhere
  task automatic ask_regions(input int unsigned n);
    int unsigned t, l, b, r;
    for (int unsigned i = 0; i < n; i++) begin
      if ($urandom_range(4) != 0) begin
        t = $urandom_range(rows_now - 1);
        b = $urandom_range(rows_now - 1, t);
        l = $urandom_range(cols_now - 1);
        r = $urandom_range(cols_now - 1, l);
        send_query(COORD_W'(t), COORD_W'(l), COORD_W'(b), COORD_W'(r));
      end else begin
        send_query(COORD_W'($urandom), COORD_W'($urandom),
                   COORD_W'($urandom), COORD_W'($urandom));
      end
    end
  endtask

  task automatic random_phase();
    int unsigned sel;
    logic [CFG_DATA_W-1:0] rows_raw;
    logic [CFG_DATA_W-1:0] cols_raw;
    int unsigned n_regions;
    settle();
    // pick a size; the largest tables keep the other side narrow
    sel = $urandom_range(9);
    case (sel)
      0: begin
        rows_raw = '0;
        cols_raw = CFG_DATA_W'($urandom_range(127, 65));
      end
      1: begin
        rows_raw = CFG_DATA_W'($urandom_range(127, 65));
        cols_raw = CFG_DATA_W'($urandom_range(2, 1));
      end
      2: begin
        rows_raw = CFG_DATA_W'(DEF_MAX_ROWS);
        cols_raw = CFG_DATA_W'($urandom_range(2));
      end
      3: begin
        rows_raw = CFG_DATA_W'($urandom_range(2, 1));
        cols_raw = CFG_DATA_W'(DEF_MAX_COLS);
      end
      default: begin
        rows_raw = CFG_DATA_W'($urandom_range(8, 1));
        cols_raw = CFG_DATA_W'($urandom_range(8, 1));
      end
    endcase
    if (sel >= 4 && cols_now <= 8 && $urandom_range(4) == 0) begin
      write_reg(CFG_ROWS, rows_raw);
    end else if ($urandom_range(1) == 0) begin
      write_reg(CFG_ROWS, rows_raw);
      write_reg(CFG_COLS, cols_raw);
    end else begin
      write_reg(CFG_COLS, cols_raw);
      write_reg(CFG_ROWS, rows_raw);
    end
    if ($urandom_range(4) == 0)
      write_reg($urandom_range(1) ? CFG_SPARE_A : CFG_SPARE_B, CFG_DATA_W'($urandom));
    fill_table();
    n_regions = $urandom_range(24, 6);
    // once: stall the receiver so the block backs up into the input
    if (!hold_done) begin
      hold_done  = 1'b1;
      rx_hold_go = 1'b1;
      n_regions  = 30;
    end
    ask_regions(n_regions);
    // reload over a complete table
    if ($urandom_range(3) == 0) begin
      fill_table();
      ask_regions($urandom_range(12, 4));
    end
  endtask

  initial begin
    rst_n                = 1'b0;
    cfg_we               = 1'b0;
    cfg_index            = '0;
    cfg_data             = '0;
    in_bus.valid         = 1'b0;
    in_bus.action        = ACT_LOAD;
    in_bus.element_value = '0;
    in_bus.top_row       = '0;
    in_bus.left_col      = '0;
    in_bus.bottom_row    = '0;
    in_bus.right_col     = '0;
    out_bus.ready        = 1'b0;
    rows_now             = DEF_MAX_ROWS;
    cols_now             = DEF_MAX_COLS;
    repeat (9) @(posedge clk);
    @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);

    // query straight after reset, then a partial load cut short by a size write
    send_query(0, 0, 63, 63);
    repeat (3) send_load(pick_element());
    settle();
    write_reg(CFG_ROWS, 2);
    write_reg(CFG_COLS, 2);

    // 2x2 table of extremes, with a query before it is complete
    send_load(16'sh7FFF);
    send_load(16'sh8000);
    send_query(0, 0, 1, 1);
    send_load(16'sh8000);
    send_load(16'sh7FFF);
    send_query(0, 0, 1, 1);
    send_query(1, 1, 1, 1);
    send_query(0, 1, 1, 1);
    send_query(1, 0, 1, 1);
    send_query(1, 0, 0, 1);
    send_query(0, 1, 1, 0);
    send_query(0, 0, 2, 1);
    send_query(0, 0, 1, 2);
    send_query(63, 63, 63, 63);

    // load over a complete table drops it until refilled
    send_load(16'sh7FFF);
    send_query(0, 0, 0, 0);
    repeat (3) send_load(pick_element());
    send_query(0, 0, 1, 1);

    // writes to unused indexes leave the table as it is
    settle();
    write_reg(CFG_SPARE_A, 7'h7F);
    write_reg(CFG_SPARE_B, 7'h00);
    send_query(0, 0, 1, 1);

    while (words_sent < WORD_TARGET) random_phase();

    settle();
    repeat (16) @(negedge clk);
    if (mismatch_total == 0 && words_waiting == 0) begin
      $display("*** PASSED ***");
    end else begin
      $display("*** FAILED ***");
    end
    $finish;
  end

endmodule
